/* design/kmhf_pkg.sv */
// Shared types, constants and helper functions of the k-mer read pair filter.
package kmhf_pkg;

    localparam int TABLE_AW      = 16;
    localparam int TABLE_ENTRIES = 1 << TABLE_AW;
    localparam int MAX_KMER      = 32;

    localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;
    localparam int HASH_SHIFT = 29;
    localparam int HASH_W     = TABLE_AW + HASH_SHIFT;
    localparam int PP_LO_W    = 23;
    localparam int PP_HI_W    = HASH_W - PP_LO_W;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_MATE1  = 2'd1;
    localparam logic [1:0] KIND_MATE2  = 2'd2;

    localparam logic [1:0] OP_LOOKUP  = 2'd0;
    localparam logic [1:0] OP_INS_FWD = 2'd1;
    localparam logic [1:0] OP_INS_RC  = 2'd2;
    localparam logic [1:0] OP_DECIDE  = 2'd3;

    localparam logic [1:0] CFG_KMER_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_MIN_QUALITY   = 2'd1;
    localparam logic [1:0] CFG_HIT_THRESHOLD = 2'd2;

    localparam logic [2:0] BASE_N        = 3'd4;
    localparam logic [8:0] HIT_MAX       = 9'd511;
    localparam logic       RES_INSERT    = 1'b0;
    localparam logic       RES_PAIR      = 1'b1;

    typedef struct packed {
        logic [1:0]  code;
        logic        mate;
        logic [63:0] key;
    } t_op;

    function automatic logic [5:0] eff_k(input logic [5:0] len);
        logic [5:0] k;
        k = len;
        if (len == 6'd0) begin
            k = 6'd1;
        end else if (len > 6'(MAX_KMER)) begin
            k = 6'(MAX_KMER);
        end
        return k;
    endfunction

    function automatic logic [63:0] kmask(input logic [5:0] k);
        logic [63:0] m;
        if (k >= 6'(MAX_KMER)) begin
            m = '1;
        end else begin
            m = ~({64{1'b1}} << {k, 1'b0});
        end
        return m;
    endfunction

    function automatic logic [63:0] rev_comp(input logic [63:0] x, input logic [5:0] k);
        logic [63:0] inv;
        logic [63:0] rev;
        logic [6:0]  shamt;
        inv = ~x;
        for (int i = 0; i < 32; i++) begin
            rev[2*i +: 2] = inv[2*(31-i) +: 2];
        end
        shamt = 7'd64 - {k, 1'b0};
        return rev >> shamt;
    endfunction

endpackage

/* design/kmhf_front.sv */
// Input stage: base window and run tracking, insert splitting into two table operations.
module kmhf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_kind,
    input  logic [63:0]      i_key,
    input  logic [2:0]       i_base_code,
    input  logic [6:0]       i_quality,
    input  logic             i_last_base,
    input  logic [5:0]       i_k,
    input  logic [6:0]       i_min_quality,
    input  logic             i_hold,
    output logic             o_op_valid,
    output kmhf_pkg::t_op    o_op,
    input  logic             i_op_ready
);
    import kmhf_pkg::*;

    logic [63:0] r_window;
    logic [63:0] n_window;
    logic [5:0]  r_run;
    logic [5:0]  n_run;
    logic        r_rc_pend;
    logic        n_rc_pend;
    logic [63:0] r_ins_key;
    logic        r_op_valid;
    t_op         r_op;

    logic        slot_free;
    logic        accept;
    logic [63:0] mask;
    logic        base_bad;
    logic [63:0] win_shift;
    logic [5:0]  run_inc;
    logic        emit;
    t_op         emit_op;

    assign slot_free  = !r_op_valid || i_op_ready;
    assign o_in_ready = !i_hold && !r_rc_pend && slot_free;
    assign accept     = i_in_valid && o_in_ready;
    assign mask       = kmask(i_k);
    assign base_bad   = (i_base_code >= BASE_N) || (i_quality < i_min_quality);
    assign win_shift  = {r_window[61:0], i_base_code[1:0]};
    assign run_inc    = (r_run == 6'd63) ? r_run : r_run + 6'd1;

    always_comb begin
        n_window  = r_window;
        n_run     = r_run;
        n_rc_pend = r_rc_pend;
        emit      = 1'b0;
        emit_op   = '0;
        if (r_rc_pend && slot_free) begin
            emit         = 1'b1;
            emit_op.code = OP_INS_RC;
            emit_op.key  = rev_comp(r_ins_key, i_k);
            n_rc_pend    = 1'b0;
        end else if (accept) begin
            case (i_kind) inside
                KIND_INSERT: begin
                    emit         = 1'b1;
                    emit_op.code = OP_INS_FWD;
                    emit_op.key  = i_key & mask;
                    n_rc_pend    = 1'b1;
                end
                KIND_MATE1, KIND_MATE2: begin
                    if (i_last_base) begin
                        n_window = '0;
                        n_run    = '0;
                        if (i_kind == KIND_MATE2) begin
                            emit         = 1'b1;
                            emit_op.code = OP_DECIDE;
                        end
                    end else if (base_bad) begin
                        n_run = '0;
                    end else begin
                        n_window = win_shift;
                        n_run    = run_inc;
                        if (run_inc >= i_k) begin
                            emit         = 1'b1;
                            emit_op.code = OP_LOOKUP;
                            emit_op.mate = (i_kind == KIND_MATE2);
                            emit_op.key  = win_shift & mask;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= '0;
            r_run      <= '0;
            r_rc_pend  <= 1'b0;
            r_op_valid <= 1'b0;
        end else begin
            r_window  <= n_window;
            r_run     <= n_run;
            r_rc_pend <= n_rc_pend;
            if (slot_free) begin
                r_op_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free && emit) begin
            r_op <= emit_op;
        end
        if (accept && i_kind == KIND_INSERT) begin
            r_ins_key <= i_key & mask;
        end
    end

    assign o_op_valid = r_op_valid;
    assign o_op       = r_op;

endmodule

/* design/kmhf_hash.sv */
// Two-stage pipelined multiplicative hash that maps a key to its home slot.
module kmhf_hash (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_op_valid,
    output logic                           o_op_ready,
    input  kmhf_pkg::t_op                  i_op,
    output logic                           o_op_valid,
    output kmhf_pkg::t_op                  o_op,
    output logic [kmhf_pkg::TABLE_AW-1:0]  o_slot,
    input  logic                           i_op_ready
);
    import kmhf_pkg::*;

    localparam logic [PP_LO_W-1:0] C_LO = HASH_MULT[PP_LO_W-1:0];
    localparam logic [PP_HI_W-1:0] C_HI = HASH_MULT[HASH_W-1:PP_LO_W];

    logic                  r_h1_valid;
    t_op                   r_h1_op;
    logic [HASH_W-1:0]     r_pp0;
    logic [PP_HI_W-1:0]    r_pp1;
    logic [PP_HI_W-1:0]    r_pp2;
    logic                  r_h2_valid;
    t_op                   r_h2_op;
    logic [TABLE_AW-1:0]   r_slot;

    logic                  adv1;
    logic                  adv2;
    logic [PP_LO_W-1:0]    a_lo;
    logic [PP_HI_W-1:0]    a_hi;
    logic [2*PP_LO_W-1:0]  p0;
    logic [2*PP_LO_W-1:0]  p1;
    logic [2*PP_LO_W-1:0]  p2;
    logic [PP_HI_W-1:0]    mid_sum;
    logic [HASH_W-1:0]     h;
    logic [TABLE_AW-1:0]   slot;

    assign adv2       = !r_h2_valid || i_op_ready;
    assign adv1       = !r_h1_valid || adv2;
    assign o_op_ready = adv1;

    assign a_lo = i_op.key[PP_LO_W-1:0];
    assign a_hi = i_op.key[HASH_W-1:PP_LO_W];
    assign p0   = (2*PP_LO_W)'(a_lo) * (2*PP_LO_W)'(C_LO);
    assign p1   = (2*PP_LO_W)'(a_lo) * (2*PP_LO_W)'(C_HI);
    assign p2   = (2*PP_LO_W)'(a_hi) * (2*PP_LO_W)'(C_LO);

    assign mid_sum = r_pp1 + r_pp2;
    assign h       = r_pp0 + {mid_sum, {PP_LO_W{1'b0}}};
    assign slot    = h[TABLE_AW-1:0] ^ h[HASH_W-1:HASH_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1_valid <= 1'b0;
            r_h2_valid <= 1'b0;
        end else begin
            if (adv1) begin
                r_h1_valid <= i_op_valid;
            end
            if (adv2) begin
                r_h2_valid <= r_h1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_h1_op <= i_op;
            r_pp0   <= p0[HASH_W-1:0];
            r_pp1   <= p1[PP_HI_W-1:0];
            r_pp2   <= p2[PP_HI_W-1:0];
        end
        if (adv2) begin
            r_h2_op <= r_h1_op;
            r_slot  <= slot;
        end
    end

    assign o_op_valid = r_h2_valid;
    assign o_op       = r_h2_op;
    assign o_slot     = r_slot;

endmodule

/* design/kmhf_probe.sv */
// Key table memory with clearing pass, linear probe engine, hit counters and result register.
module kmhf_probe (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_op_valid,
    output logic                           o_op_ready,
    input  kmhf_pkg::t_op                  i_op,
    input  logic [kmhf_pkg::TABLE_AW-1:0]  i_slot,
    input  logic [8:0]                     i_threshold,
    output logic                           o_clearing,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_result_kind,
    output logic                           o_status,
    output logic                           o_pair_passes,
    output logic [8:0]                     o_mate_one_hits,
    output logic [8:0]                     o_mate_two_hits
);
    import kmhf_pkg::*;

    logic [64:0]          r_mem [TABLE_ENTRIES];
    logic [64:0]          r_rd_data;
    logic                 r_byp;
    logic [64:0]          r_byp_data;
    logic                 r_clr_busy;
    logic [TABLE_AW-1:0]  r_clr_addr;
    logic                 r_p_valid;
    t_op                  r_p_op;
    logic [TABLE_AW-1:0]  r_p_idx;
    logic [TABLE_AW-1:0]  r_p_cnt;
    logic [8:0]           r_hits1;
    logic [8:0]           r_hits2;
    logic                 r_ins_fail;
    logic                 r_out_valid;
    logic                 r_res_kind;
    logic                 r_status;
    logic                 r_pass;
    logic [8:0]           r_out_hits1;
    logic [8:0]           r_out_hits2;

    logic [64:0]          ent;
    logic                 ent_valid;
    logic                 ent_match;
    logic                 last_probe;
    logic                 out_free;
    logic                 is_lookup;
    logic                 is_ins;
    logic                 resolved;
    logic                 needs_out;
    logic                 done;
    logic                 step;
    logic                 hit;
    logic                 fail_now;
    logic                 take;
    logic                 load;
    logic                 rd_en;
    logic [TABLE_AW-1:0]  rd_addr;
    logic                 wr_en;
    logic [TABLE_AW-1:0]  wr_addr;
    logic [64:0]          wr_data;

    assign ent        = r_byp ? r_byp_data : r_rd_data;
    assign ent_valid  = ent[64];
    assign ent_match  = (ent[63:0] == r_p_op.key);
    assign last_probe = (r_p_cnt == '1);
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        is_lookup = (r_p_op.code == OP_LOOKUP);
        is_ins    = (r_p_op.code == OP_INS_FWD) || (r_p_op.code == OP_INS_RC);
        needs_out = (r_p_op.code == OP_INS_RC) || (r_p_op.code == OP_DECIDE);
        resolved  = (r_p_op.code == OP_DECIDE) || !ent_valid || ent_match || last_probe;
        done      = r_p_valid && resolved && (!needs_out || out_free);
        step      = r_p_valid && !resolved;
        hit       = is_lookup && ent_valid && ent_match;
        fail_now  = ent_valid && !ent_match;
        take      = !r_clr_busy && (!r_p_valid || done);
        load      = take && i_op_valid;
        rd_en     = load || step;
        rd_addr   = load ? i_slot : r_p_idx + TABLE_AW'(1);
        wr_en     = r_clr_busy || (done && is_ins && !ent_valid);
        wr_addr   = r_clr_busy ? r_clr_addr : r_p_idx;
        wr_data   = r_clr_busy ? '0 : {1'b1, r_p_op.key};
    end

    assign o_op_ready = take;
    assign o_clearing = r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data  <= r_mem[rd_addr];
            r_byp      <= wr_en && (wr_addr == rd_addr);
            r_byp_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_p_valid   <= 1'b0;
            r_hits1     <= '0;
            r_hits2     <= '0;
            r_ins_fail  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + TABLE_AW'(1);
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (take) begin
                r_p_valid <= i_op_valid;
            end
            if (done) begin
                if (hit && !r_p_op.mate && r_hits1 != HIT_MAX) begin
                    r_hits1 <= r_hits1 + 9'd1;
                end
                if (hit && r_p_op.mate && r_hits2 != HIT_MAX) begin
                    r_hits2 <= r_hits2 + 9'd1;
                end
                if (r_p_op.code == OP_DECIDE) begin
                    r_hits1 <= '0;
                    r_hits2 <= '0;
                end
                if (r_p_op.code == OP_INS_FWD) begin
                    r_ins_fail <= fail_now;
                end
            end
            if (done && needs_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_p_op  <= i_op;
            r_p_idx <= i_slot;
            r_p_cnt <= '0;
        end else if (step) begin
            r_p_idx <= r_p_idx + TABLE_AW'(1);
            r_p_cnt <= r_p_cnt + TABLE_AW'(1);
        end
        if (done && needs_out) begin
            if (r_p_op.code == OP_DECIDE) begin
                r_res_kind  <= RES_PAIR;
                r_status    <= 1'b0;
                r_pass      <= (r_hits1 >= i_threshold) || (r_hits2 >= i_threshold);
                r_out_hits1 <= r_hits1;
                r_out_hits2 <= r_hits2;
            end else begin
                r_res_kind  <= RES_INSERT;
                r_status    <= r_ins_fail || fail_now;
                r_pass      <= 1'b0;
                r_out_hits1 <= '0;
                r_out_hits2 <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_res_kind;
    assign o_status        = r_status;
    assign o_pair_passes   = r_pass;
    assign o_mate_one_hits = r_out_hits1;
    assign o_mate_two_hits = r_out_hits2;

endmodule

/* design/kmer_hit_read_pair_filter.sv */
// Top level of the k-mer set membership read pair filter.
// Input items arrive on a valid/ready channel: an insert carries a packed key, a base
// item carries one base, its quality and a last-base flag for mate one or mate two.
// Results leave on a valid/ready channel: an insert status for each insert and a pair
// decision with both hit counts after the last base of mate two.
// Registers are written through a separate valid/ready channel that is always ready,
// by index: kmer length, minimum quality, hit threshold.
// The key set is an open-addressed table of 65536 entries in one memory with a
// registered read; lookups and inserts probe linearly, one entry per cycle.
// A result passes the front op register, both hash stages, the table read and the output
// register; an insert status follows its second operation; each further probe adds a read.
// A base item is taken every cycle while the probe engine keeps up; an insert holds the input
// until its second operation is sent, since it stores the key and its reverse complement.
// After reset the table is cleared one entry per cycle, and no item is accepted until
// that pass ends; configuration writes are taken throughout.
// When the receiver stalls, one result waits in the output register and the
// pipeline keeps filling until its stages are full, then input ready drops.
module kmer_hit_read_pair_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_key,
    input  logic [2:0]  i_base_code,
    input  logic [6:0]  i_quality,
    input  logic        i_last_base,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic        o_status,
    output logic        o_pair_passes,
    output logic [8:0]  o_mate_one_hits,
    output logic [8:0]  o_mate_two_hits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import kmhf_pkg::*;

    logic [5:0]          r_kmer_length;
    logic [6:0]          r_min_quality;
    logic [8:0]          r_hit_threshold;

    logic [5:0]          k;
    logic                clearing;
    logic                f_valid;
    t_op                 f_op;
    logic                f_ready;
    logic                h_valid;
    t_op                 h_op;
    logic [TABLE_AW-1:0] h_slot;
    logic                h_ready;

    assign o_cfg_ready = 1'b1;
    assign k           = eff_k(r_kmer_length);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length   <= 6'd25;
            r_min_quality   <= 7'd0;
            r_hit_threshold <= 9'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KMER_LENGTH:   r_kmer_length   <= i_cfg_data[5:0];
                CFG_MIN_QUALITY:   r_min_quality   <= i_cfg_data[6:0];
                CFG_HIT_THRESHOLD: r_hit_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    kmhf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_base_code   (i_base_code),
        .i_quality     (i_quality),
        .i_last_base   (i_last_base),
        .i_k           (k),
        .i_min_quality (r_min_quality),
        .i_hold        (clearing),
        .o_op_valid    (f_valid),
        .o_op          (f_op),
        .i_op_ready    (f_ready)
    );

    kmhf_hash u_hash (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (f_valid),
        .o_op_ready (f_ready),
        .i_op       (f_op),
        .o_op_valid (h_valid),
        .o_op       (h_op),
        .o_slot     (h_slot),
        .i_op_ready (h_ready)
    );

    kmhf_probe u_probe (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op_valid      (h_valid),
        .o_op_ready      (h_ready),
        .i_op            (h_op),
        .i_slot          (h_slot),
        .i_threshold     (r_hit_threshold),
        .o_clearing      (clearing),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_status        (o_status),
        .o_pair_passes   (o_pair_passes),
        .o_mate_one_hits (o_mate_one_hits),
        .o_mate_two_hits (o_mate_two_hits)
    );

endmodule
